### rtl/core/irs_pkg.sv
// Shared types, constants and helper functions for the ignition relay sequencer.
package irs_pkg;

    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned PROD_W     = 23;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PEDAL_THRESHOLD = 2'd0,
        CFG_PRECHARGE_TICKS = 2'd1,
        CFG_PASS_TICKS      = 2'd2
    } cfg_index_t;

    localparam logic [6:0]  RST_PEDAL_THRESHOLD = 7'd5;
    localparam logic [15:0] RST_PRECHARGE_TICKS = 16'd5000;
    localparam logic [15:0] RST_PASS_TICKS      = 16'd100;

    typedef enum logic [2:0] {
        IGN_OFF         = 3'd0,
        IGN_ARRAY       = 3'd1,
        IGN_MOTOR_START = 3'd2,
        IGN_MOTOR_OFF   = 3'd3,
        IGN_MOTOR_RUN   = 3'd4
    } ign_state_t;

    // relay bit positions
    localparam int unsigned RL_APRE = 0;
    localparam int unsigned RL_ACON = 1;
    localparam int unsigned RL_MPRE = 2;
    localparam int unsigned RL_MCON = 3;

    typedef struct packed {
        logic [15:0] brake_reading;
        logic [15:0] regen_reading;
        logic        array_switch;
        logic        motor_switch;
    } in_req_t;

    typedef struct packed {
        logic       array_precharge_on;
        logic       array_contactor_on;
        logic       motor_precharge_on;
        logic       motor_contactor_on;
        logic       brake_light_level;
        logic       cruise_cancel;
        logic [2:0] ignition_mode;
    } out_req_t;

    typedef struct packed {
        logic [6:0]  pedal_threshold;
        logic [15:0] precharge_ticks;
        logic [15:0] pass_ticks;
    } cfg_t;

    // reading*100 > threshold*65535
    function automatic logic pedal_pressed(input logic [15:0] reading,
                                           input logic [6:0] thr);
        logic [PROD_W-1:0] lhs;
        logic [PROD_W-1:0] rhs;
        lhs = PROD_W'(reading) * PROD_W'(100);
        rhs = {thr, 16'b0} - PROD_W'(thr);
        return lhs > rhs;
    endfunction

    // switch level 0 means selected; later rules win
    function automatic ign_state_t ign_transition(input ign_state_t s,
                                                  input logic arr,
                                                  input logic mot);
        ign_state_t n;
        n = s;
        unique case (s)
            IGN_OFF:
            begin
                n = arr ? IGN_OFF : IGN_ARRAY;
            end
            IGN_ARRAY:
            begin
                if (!mot) n = IGN_MOTOR_START;
                if (!arr) n = IGN_MOTOR_OFF;
                if (mot && arr) n = IGN_OFF;
            end
            IGN_MOTOR_START:
            begin
                n = mot ? IGN_MOTOR_OFF : IGN_MOTOR_RUN;
            end
            IGN_MOTOR_OFF:
            begin
                if (!mot) n = IGN_MOTOR_START;
                if (arr && mot) n = IGN_OFF;
            end
            IGN_MOTOR_RUN:
            begin
                if (mot && !arr) n = IGN_MOTOR_OFF;
            end
            default:
            begin
                n = IGN_OFF;
            end
        endcase
        return n;
    endfunction

endpackage

### rtl/core/ignition_relay_sequencer_top.sv
// Ignition relay sequencer top level: config registers, tick handshake, result register.
//
// Usage: each request on the in channel is one millisecond tick carrying brake and
// regen readings and the array/motor key switch levels. Each tick produces exactly
// one request on the out channel with the relay levels, brake light, cruise cancel
// pulse and ignition mode after that tick's update.
// Output: the result is registered and is valid in the cycle after the tick is accepted.
// Throughput: one tick per cycle while out_ready is high; the state update is a single
// pass of counter decrement, pedal compare and mode transition feeding the result register.
// Stall: in_ready stays high while the result register is empty or being taken, so
// a held result blocks new ticks only while out_ready is low.
// Reset: rst_n clears the mode to off, the relays, the wait counter and the
// pending flags, and loads threshold 5, precharge 5000 and pass spacing 100.
// Configuration writes via cfg_wr_en/cfg_index/cfg_data take effect at once,
// indexes above 2 are ignored; write only while no tick is in flight.
module ignition_relay_sequencer_top
    import irs_pkg::*;
#(
    parameter int unsigned COUNT_WIDTH = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_req_t               in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_req_t              out_data
);

    cfg_t     cfg_reg;
    logic     out_valid_reg;
    out_req_t out_data_reg;
    out_req_t core_result;
    logic     step;

    assign in_ready  = !out_valid_reg || out_ready;
    assign step      = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    irs_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .tick   (in_data),
        .cfg    (cfg_reg),
        .result (core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pedal_threshold <= RST_PEDAL_THRESHOLD;
            cfg_reg.precharge_ticks <= RST_PRECHARGE_TICKS;
            cfg_reg.pass_ticks      <= RST_PASS_TICKS;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_PEDAL_THRESHOLD: cfg_reg.pedal_threshold <= cfg_data[6:0];
                CFG_PRECHARGE_TICKS: cfg_reg.precharge_ticks <= cfg_data;
                CFG_PASS_TICKS:      cfg_reg.pass_ticks      <= cfg_data;
                default:             cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_ready)
            out_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (step)
            out_data_reg <= core_result;
    end

endmodule

### rtl/core/irs_core.sv
// Ignition state, wait counter and relay state, advanced by one tick request.
module irs_core
    import irs_pkg::*;
#(
    parameter int unsigned COUNT_WIDTH = 16
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     step,
    input  in_req_t  tick,
    input  cfg_t     cfg,
    output out_req_t result
);

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

    ign_state_t             state_reg, state_next;
    logic [COUNT_WIDTH-1:0] wait_cnt_reg, wait_cnt_next;
    logic                   pending_reg, pending_next;
    logic                   pend_motor_reg, pend_motor_next;
    logic [3:0]             relay_reg, relay_next;
    logic                   brake_light_reg, brake_light_next;
    logic                   cancel;
    logic                   tick_event;
    ign_state_t             eval_state;
    logic [COUNT_WIDTH-1:0] pass_load;
    logic [COUNT_WIDTH-1:0] pre_load;
    logic                   pressed;

    function automatic logic [COUNT_WIDTH-1:0] sat_load(input logic [15:0] v);
        logic [32:0] ext_v;
        logic [32:0] ext_max;
        ext_v   = 33'(v);
        ext_max = 33'(CNT_MAX);
        return (ext_v > ext_max) ? CNT_MAX : COUNT_WIDTH'(v);
    endfunction

    assign pass_load  = sat_load(cfg.pass_ticks);
    assign pre_load   = sat_load(cfg.precharge_ticks);
    assign tick_event = (wait_cnt_reg == '0) || (wait_cnt_reg == COUNT_WIDTH'(1));
    assign eval_state = ign_transition(state_reg, tick.array_switch, tick.motor_switch);
    assign pressed    = pedal_pressed(tick.regen_reading, cfg.pedal_threshold)
                     || pedal_pressed(tick.brake_reading, cfg.pedal_threshold);

    // next state: mode, counter, pending flags
    always_comb
    begin
        state_next      = state_reg;
        pending_next    = pending_reg;
        pend_motor_next = pend_motor_reg;
        wait_cnt_next   = (wait_cnt_reg != '0) ? wait_cnt_reg - COUNT_WIDTH'(1) : wait_cnt_reg;
        if (tick_event)
        begin
            if (pending_reg)
            begin
                pending_next  = 1'b0;
                state_next    = eval_state;
                wait_cnt_next = pass_load;
            end
            else
            begin
                unique case (state_reg)
                    IGN_ARRAY, IGN_MOTOR_START:
                    begin
                        pend_motor_next = (state_reg == IGN_MOTOR_START);
                        pending_next    = 1'b1;
                        wait_cnt_next   = pre_load;
                    end
                    default:
                    begin
                        state_next    = eval_state;
                        wait_cnt_next = pass_load;
                    end
                endcase
            end
        end
    end

    // outputs: relays, brake light, cruise cancel
    always_comb
    begin
        relay_next       = relay_reg;
        brake_light_next = brake_light_reg;
        cancel           = 1'b0;
        if (tick_event)
        begin
            if (pending_reg)
            begin
                if (pend_motor_reg)
                    relay_next[RL_MCON] = 1'b1;
                else
                    relay_next[RL_ACON] = 1'b1;
            end
            else
            begin
                brake_light_next = !pressed;
                cancel           = pressed;
                unique case (state_reg)
                    IGN_OFF:
                    begin
                        relay_next[RL_APRE] = 1'b0;
                        relay_next[RL_ACON] = 1'b0;
                    end
                    IGN_ARRAY:
                    begin
                        relay_next[RL_APRE] = 1'b1;
                    end
                    IGN_MOTOR_START:
                    begin
                        relay_next[RL_MPRE] = 1'b1;
                    end
                    IGN_MOTOR_OFF:
                    begin
                        relay_next[RL_MPRE] = 1'b0;
                        relay_next[RL_MCON] = 1'b0;
                    end
                    default:
                    begin
                        relay_next = relay_reg;
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        result.array_precharge_on = relay_next[RL_APRE];
        result.array_contactor_on = relay_next[RL_ACON];
        result.motor_precharge_on = relay_next[RL_MPRE];
        result.motor_contactor_on = relay_next[RL_MCON];
        result.brake_light_level  = brake_light_next;
        result.cruise_cancel      = cancel;
        result.ignition_mode      = state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= IGN_OFF;
            wait_cnt_reg    <= '0;
            pending_reg     <= 1'b0;
            pend_motor_reg  <= 1'b0;
            relay_reg       <= '0;
            brake_light_reg <= 1'b0;
        end
        else if (step)
        begin
            state_reg       <= state_next;
            wait_cnt_reg    <= wait_cnt_next;
            pending_reg     <= pending_next;
            pend_motor_reg  <= pend_motor_next;
            relay_reg       <= relay_next;
            brake_light_reg <= brake_light_next;
        end
    end

endmodule
